/* rtl/shsd_pkg.sv */
// shsd_pkg: shared types and constants for the stream header sync and deframer.
// Holds the header pattern, field widths and result kind codes.
// No dependencies; compile first.
`default_nettype none

package shsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned HDR_LEN  = 7;
    localparam int unsigned POS_W    = 3;

    localparam logic [BYTE_W-1:0] CHAR_LT = 8'h3C;   // '<'
    localparam logic [BYTE_W-1:0] CHAR_R  = 8'h52;   // 'R'

    // result kind codes
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // one result item
    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              reverse_variant;
        logic              first_in_packet;
        logic              last_in_packet;
    } t_result;

    // header pattern "<ABPS>\n", indexed by match position
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h3C;   // '<'
            3'd1:    c = 8'h41;   // 'A'
            3'd2:    c = 8'h42;   // 'B'
            3'd3:    c = 8'h50;   // 'P'
            3'd4:    c = 8'h53;   // 'S'
            3'd5:    c = 8'h3E;   // '>'
            3'd6:    c = 8'h0A;   // line feed
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/shsd_in_if.sv */
// shsd_in_if: input byte channel, valid/ready with one received byte.
// Depends on shsd_pkg.
`default_nettype none

interface shsd_in_if;
    logic                        valid;
    logic                        ready;
    logic [shsd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/shsd_out_if.sv */
// shsd_out_if: result channel, valid/ready with header events and payload bytes.
// Depends on shsd_pkg.
`default_nettype none

interface shsd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [shsd_pkg::BYTE_W-1:0] payload_byte;
    logic                        reverse_variant;
    logic                        first_in_packet;
    logic                        last_in_packet;

    modport source (output valid, output result_kind, output payload_byte,
                    output reverse_variant, output first_in_packet,
                    output last_in_packet, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input reverse_variant, input first_in_packet,
                    input last_in_packet, output ready);
endinterface

`default_nettype wire

/* rtl/stream_header_sync_and_deframer.sv */
// stream_header_sync_and_deframer: header hunt, length parsing and payload framing.
// Depends on shsd_pkg, shsd_in_if and shsd_out_if.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  i_rx     | in        | rx_byte
//  o_res    | out       | result_kind, payload_byte, reverse_variant,
//           |           | first_in_packet, last_in_packet
//  i_cfg_*  | in        | length_big_endian (write enable + data)
//
// One byte per cycle unless the output stalls: a byte is held in the input register,
// then the state update and the result register load happen together as it moves on.
// Each processed byte updates the parser state and, where it yields a result, the result register.
// A stalled result holds the input register and parser state; i_rx.ready stays
// high as long as the held byte can move on. Synchronous active-low reset returns
// the block to header hunt with big-endian lengths.
`default_nettype none

module stream_header_sync_and_deframer (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_data,
    shsd_in_if.sink        i_rx,
    shsd_out_if.source     o_res
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    localparam logic [shsd_pkg::POS_W-1:0] POS_LAST =
        shsd_pkg::POS_W'(shsd_pkg::HDR_LEN - 1);

    // configuration
    logic r_big_endian;

    // input stage
    logic                        r_in_valid;
    logic [shsd_pkg::BYTE_W-1:0] r_in_byte;

    // parser state
    t_phase                       r_phase,   n_phase;
    logic [shsd_pkg::POS_W-1:0]   r_pos,     n_pos;
    logic                         r_flag,    n_flag;
    logic [1:0]                   r_cnt,     n_cnt;
    logic [shsd_pkg::LEN_W-1:0]   r_acc,     n_acc;
    logic [shsd_pkg::LEN_W-1:0]   r_rem,     n_rem;

    // result stage
    logic                r_out_valid;
    shsd_pkg::t_result   r_out;
    logic                n_res_valid;
    shsd_pkg::t_result   n_res;

    logic out_free;
    logic advance;

    logic [shsd_pkg::POS_W-1:0]  hunt_pos;
    logic                        hdr_match;
    logic                        var_hit;
    logic [shsd_pkg::LEN_W-1:0]  rem_dec;
    logic                        last_byte;

    assign out_free   = !r_out_valid || o_res.ready;
    assign advance    = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;

    assign o_res.valid           = r_out_valid;
    assign o_res.result_kind     = r_out.result_kind;
    assign o_res.payload_byte    = r_out.payload_byte;
    assign o_res.reverse_variant = r_out.reverse_variant;
    assign o_res.first_in_packet = r_out.first_in_packet;
    assign o_res.last_in_packet  = r_out.last_in_packet;

    // header compare helpers
    assign hunt_pos  = (r_pos > POS_LAST) ? '0 : r_pos;
    assign hdr_match = (shsd_pkg::hdr_byte(hunt_pos) == r_in_byte);
    assign var_hit   = (hunt_pos == shsd_pkg::POS_W'(1)) && (r_in_byte == shsd_pkg::CHAR_R);

    // payload countdown helpers
    assign last_byte = (r_rem[shsd_pkg::LEN_W-1:1] == '0);
    assign rem_dec   = r_rem - shsd_pkg::LEN_W'(r_rem != '0);

    // compute next state and result for the held byte
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_flag      = r_flag;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_res_valid = 1'b0;
        n_res       = '0;

        case (r_phase)
            PH_LEN: begin
                if (r_big_endian) begin
                    n_acc = {r_acc[shsd_pkg::LEN_W-shsd_pkg::BYTE_W-1:0], r_in_byte};
                end else begin
                    n_acc = r_acc | (shsd_pkg::LEN_W'(r_in_byte) << {r_cnt, 3'b000});
                end
                n_cnt = r_cnt + 2'd1;
                // fourth length byte: start payload unless the length is zero
                if (r_cnt == 2'd3 && n_acc != '0) begin
                    n_rem   = n_acc;
                    n_phase = PH_DATA;
                end
            end

            PH_DATA: begin
                n_res_valid           = 1'b1;
                n_res.result_kind     = shsd_pkg::KIND_PAYLOAD;
                n_res.payload_byte    = r_in_byte;
                n_res.reverse_variant = r_flag;
                n_res.first_in_packet = (r_rem == r_acc);
                n_res.last_in_packet  = last_byte;
                n_rem                 = rem_dec;
                if (last_byte) begin
                    n_phase = PH_LEN;
                    n_cnt   = '0;
                    n_acc   = '0;
                end
            end

            default: begin
                // header hunt, also for the unused phase code
                n_phase = PH_HUNT;
                if (!hdr_match && !var_hit) begin
                    n_pos = (r_in_byte == shsd_pkg::CHAR_LT) ? shsd_pkg::POS_W'(1) : '0;
                end else begin
                    if (var_hit) begin
                        n_flag = 1'b1;
                    end
                    if (hunt_pos == POS_LAST) begin
                        n_pos                 = '0;
                        n_phase               = PH_LEN;
                        n_cnt                 = '0;
                        n_acc                 = '0;
                        n_rem                 = '0;
                        n_res_valid           = 1'b1;
                        n_res.result_kind     = shsd_pkg::KIND_HEADER;
                        n_res.reverse_variant = n_flag;
                    end else begin
                        n_pos = hunt_pos + shsd_pkg::POS_W'(1);
                    end
                end
            end
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b1;
        end else if (i_cfg_we) begin
            r_big_endian <= i_cfg_data;
        end
    end

    // input register: take a transfer whenever ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // parser state: advance once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_flag  <= 1'b0;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_flag  <= n_flag;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

    // result register: load on advance, drop after the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_res_valid) begin
            r_out <= n_res;
        end
    end

endmodule

`default_nettype wire
